[src/ata_pkg.sv]
// shared types and constants of the association table address allocator
package ata_pkg;

  localparam logic CMD_ASSOC    = 1'b0;
  localparam logic CMD_DISASSOC = 1'b1;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_EXISTING  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] REG_FALLBACK = 2'd0;
  localparam logic [1:0] REG_BASE     = 2'd1;

  localparam logic [15:0] RESET_FALLBACK = 16'hFFFE;
  localparam logic [15:0] RESET_BASE     = 16'h1201;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic finish;
  } ata_ctl_t;

  typedef struct packed {
    logic scan_last;
    logic need_sa;
  } ata_stat_t;

endpackage

[src/ata_ctrl.sv]
// controller state machine of the association table address allocator
module ata_ctrl
  import ata_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ata_ctl_t  ctl,
  input  ata_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LAST   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_READ   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = stat.need_sa ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign ctl.load   = (state == S_IDLE) && start;
  assign ctl.scan   = (state == S_SCAN);
  assign ctl.decide = (state == S_DECIDE);
  assign ctl.finish = (state == S_READ);

endmodule

[src/ata_dp.sv]
// datapath of the association table address allocator: table, scan and result
module ata_dp
  import ata_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ata_ctl_t    ctl,
  output ata_stat_t   stat,
  input  logic        cmd,
  input  logic [63:0] device_long_address,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic [15:0] short_address,
  output logic [2:0]  status
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic [63:0] la_mem [TABLE_ENTRIES];
  logic [15:0] sa_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic [15:0] fallback_reg;
  logic [15:0] base_reg;
  logic [15:0] alloc_count;

  logic        req_cmd;
  logic [63:0] req_addr;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] rd_idx;
  logic        rd_pend;
  logic [63:0] la_q;
  logic [15:0] sa_q;
  logic        match_found;
  logic [IW-1:0] match_idx;
  logic        free_found;
  logic [IW-1:0] free_idx;

  logic        alloc_we;
  logic        remove_we;
  logic [15:0] new_sa;
  logic [15:0] res_sa_next;
  logic [2:0]  res_status_next;

  assign new_sa    = base_reg + alloc_count;
  assign alloc_we  = ctl.decide && (req_cmd == CMD_ASSOC) && !match_found && free_found;
  assign remove_we = ctl.decide && (req_cmd == CMD_DISASSOC) && match_found;

  assign stat.scan_last = (scan_idx == LAST_IDX);
  assign stat.need_sa   = (req_cmd == CMD_ASSOC) && match_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_reg <= RESET_FALLBACK;
      base_reg     <= RESET_BASE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FALLBACK: fallback_reg <= wr_data;
        REG_BASE:     base_reg     <= wr_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd  <= cmd;
      req_addr <= device_long_address;
    end
    if (ctl.load) begin
      scan_idx <= '0;
    end else if (ctl.scan && !stat.scan_last) begin
      scan_idx <= scan_idx + 1'b1;
    end
    rd_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) la_q <= la_mem[scan_idx];
    if (alloc_we) la_mem[free_idx] <= req_addr;
  end

  always_ff @(posedge clk) begin
    if (ctl.decide) sa_q <= sa_mem[match_idx];
    if (alloc_we) sa_mem[free_idx] <= new_sa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      rd_pend <= ctl.scan;
      if (ctl.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (rd_pend) begin
        if (entry_valid[rd_idx] && (la_q == req_addr) && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= rd_idx;
        end
        if (!entry_valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      alloc_count <= '0;
    end else begin
      if (alloc_we) begin
        entry_valid[free_idx] <= 1'b1;
        alloc_count           <= alloc_count + 16'd1;
      end
      if (remove_we) entry_valid[match_idx] <= 1'b0;
    end
  end

  always_comb begin
    res_sa_next     = 16'd0;
    res_status_next = ST_NOT_FOUND;
    if (req_cmd == CMD_ASSOC) begin
      if (free_found) begin
        res_sa_next     = new_sa;
        res_status_next = ST_NEW;
      end else begin
        res_sa_next     = fallback_reg;
        res_status_next = ST_FULL;
      end
    end else if (match_found) begin
      res_status_next = ST_REMOVED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish || (ctl.decide && !stat.need_sa);
    end
    if (ctl.finish) begin
      short_address <= sa_q;
      status        <= ST_EXISTING;
    end else if (ctl.decide) begin
      short_address <= res_sa_next;
      status        <= res_status_next;
    end
  end

`ifndef ASSERT_OFF
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> done && (status == ST_EXISTING))
    else $error("existing entry lookup gave no result");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    alloc_we |=> alloc_count == $past(alloc_count) + 16'd1)
    else $error("allocation count did not advance");

  a_match_not_free: assert property (@(posedge clk) disable iff (rst)
    (match_found && free_found) |-> (match_idx != free_idx))
    else $error("one entry both matched and free");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_REMOVED || status == ST_NOT_FOUND)) |-> (short_address == 16'd0))
    else $error("disassociate item returned nonzero short address");
`endif

endmodule

[src/association_table_address_allocator.sv]
// association table address allocator: controller and table datapath
// flow: start loads the request, the entry scan compares every table entry, then the
//   result is decided; an associate of an address already in the table adds a short
//   address memory read. A new item is taken only while busy is low; the scan reads
//   one long address memory word per cycle; done stands one cycle
// reset: synchronous rst clears the valid flags and the count, presets the registers
module association_table_address_allocator
  import ata_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [63:0] device_long_address,
  output logic        done,
  output logic [15:0] short_address,
  output logic [2:0]  status,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  ata_ctl_t  ctl;
  ata_stat_t stat;

  ata_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  ata_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .stat                (stat),
    .cmd                 (cmd),
    .device_long_address (device_long_address),
    .wr_en               (wr_en),
    .wr_index            (wr_index),
    .wr_data             (wr_data),
    .done                (done),
    .short_address       (short_address),
    .status              (status)
  );

endmodule
